[rtl/qse_pkg.sv]
// Shared types for the quicksort engine.
// Holds the sequencer state encoding; no dependencies.
package qse_pkg;

  typedef enum logic [4:0] {
    S_LOAD,
    S_INIT,
    S_POP,
    S_RANGE,
    S_PIVOT,
    S_A_ISS,
    S_A_CHK,
    S_B_ISS,
    S_B_CHK,
    S_SWAP_A,
    S_SWAP_B,
    S_FIX_LO,
    S_FIX_HI,
    S_PUSH_L,
    S_PUSH_R,
    S_O_ISS,
    S_O_RD,
    S_O_HOLD
  } qse_state_t;

endpackage

[rtl/quicksort_engine.sv]
// Quicksort engine top level: element store, range stack and sort sequencer; uses qse_pkg.
// Loading accepts an item whenever one is offered, and the block is not ready again until
// the set is out. The in-place sort uses one store read port and one write port, and each
// sorted result is read out through S_O_ISS, S_O_RD and S_O_HOLD, the last waiting for
// out_tready. Reset clears the state, the element count, the range stack pointer, the
// output valid and the overflow flag.
module quicksort_engine #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value_res
  output logic        out_tlast,  // is_last_res
  output logic [0:0]  out_tuser   // overflow
);
  import qse_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qse_state_t state_r, state_nxt;

  logic signed [31:0] mem [DEPTH];
  logic [2*AW-1:0]    stack [DEPTH];

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic          drop_r, drop_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0] a_r, a_nxt, b_r, b_nxt, k_r, k_nxt;
  logic signed [31:0] pv_r, pv_nxt, va_r, va_nxt, vb_r, vb_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  logic        out_last_r, out_last_nxt;

  logic                we;
  logic [AW-1:0]       wa, ra;
  logic signed [31:0]  wd;
  logic signed [31:0]  rd_data_r;

  logic                stk_we;
  logic [AW-1:0]       stk_wa, stk_ra;
  logic [2*AW-1:0]     stk_wd, stk_q_r;

  logic in_acc, push_l, push_r, sp_room;

  assign in_acc  = in_tvalid && in_tready;
  assign push_l  = {1'b0, b_r} > ({1'b0, lo_r} + 1'b1);
  assign push_r  = ({1'b0, b_r} + 1'b1) < {1'b0, hi_r};
  assign sp_room = sp_r < CW'(DEPTH);
  assign stk_ra  = AW'(sp_r - 1'b1);

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = drop_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack[stk_wa] <= stk_wd;
    end
    stk_q_r <= stack[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      sp_r        <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sp_r        <= sp_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    k_r         <= k_nxt;
    pv_r        <= pv_nxt;
    va_r        <= va_nxt;
    vb_r        <= vb_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sp_nxt        = sp_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    pv_nxt        = pv_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    we            = 1'b0;
    wa            = '0;
    wd            = in_tdata;
    ra            = '0;
    stk_we        = 1'b0;
    stk_wa        = '0;
    stk_wd        = '0;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CW'(DEPTH)) begin
            we      = 1'b1;
            wa      = cnt_r[AW-1:0];
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        k_nxt = '0;
        if (cnt_r < CW'(2)) begin
          state_nxt = S_O_ISS;
        end else begin
          stk_we    = 1'b1;
          stk_wa    = '0;
          stk_wd    = {AW'(0), AW'(cnt_r - 1'b1)};
          sp_nxt    = CW'(1);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_O_ISS;
        end else begin
          sp_nxt    = sp_r - 1'b1;
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        lo_nxt    = stk_q_r[2*AW-1:AW];
        hi_nxt    = stk_q_r[AW-1:0];
        ra        = stk_q_r[2*AW-1:AW];
        state_nxt = S_PIVOT;
      end
      S_PIVOT: begin
        pv_nxt    = rd_data_r;
        a_nxt     = lo_r;
        b_nxt     = hi_r;
        state_nxt = S_A_ISS;
      end
      S_A_ISS: begin
        ra        = a_r;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (rd_data_r <= pv_r && a_r < hi_r) begin
          a_nxt = a_r + 1'b1;
          ra    = a_r + 1'b1;
        end else begin
          va_nxt    = rd_data_r;
          state_nxt = S_B_ISS;
        end
      end
      S_B_ISS: begin
        ra        = b_r;
        state_nxt = S_B_CHK;
      end
      S_B_CHK: begin
        if (rd_data_r > pv_r) begin
          b_nxt = b_r - 1'b1;
          ra    = b_r - 1'b1;
        end else begin
          vb_nxt    = rd_data_r;
          state_nxt = (a_r < b_r) ? S_SWAP_A : S_FIX_LO;
        end
      end
      S_SWAP_A: begin
        we        = 1'b1;
        wa        = a_r;
        wd        = vb_r;
        state_nxt = S_SWAP_B;
      end
      S_SWAP_B: begin
        we        = 1'b1;
        wa        = b_r;
        wd        = va_r;
        state_nxt = S_A_ISS;
      end
      S_FIX_LO: begin
        we        = 1'b1;
        wa        = lo_r;
        wd        = vb_r;
        state_nxt = S_FIX_HI;
      end
      S_FIX_HI: begin
        we        = 1'b1;
        wa        = b_r;
        wd        = pv_r;
        state_nxt = S_PUSH_L;
      end
      S_PUSH_L: begin
        if (push_l && sp_room) begin
          stk_we = 1'b1;
          stk_wa = sp_r[AW-1:0];
          stk_wd = {lo_r, AW'(b_r - 1'b1)};
          sp_nxt = sp_r + 1'b1;
        end
        state_nxt = S_PUSH_R;
      end
      S_PUSH_R: begin
        if (push_r && sp_room) begin
          stk_we = 1'b1;
          stk_wa = sp_r[AW-1:0];
          stk_wd = {AW'(b_r + 1'b1), hi_r};
          sp_nxt = sp_r + 1'b1;
        end
        state_nxt = S_POP;
      end
      S_O_ISS: begin
        ra        = k_r;
        state_nxt = S_O_RD;
      end
      S_O_RD: begin
        out_value_nxt = rd_data_r;
        out_last_nxt  = (CW'(k_r) + 1'b1) == cnt_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_O_HOLD;
      end
      S_O_HOLD: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_O_ISS;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count exceeds store depth");

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(DEPTH))
    else $error("range stack pointer exceeds depth");

  a_end_of_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && cnt_r == '0 && !drop_r)
    else $error("block did not return to empty after the last result");

endmodule

[sim/testbench.sv]
// Self-checking testbench for quicksort_engine: loads sets of signed elements and
// checks that each set comes back in ascending order with the right end and drop flags.
// Depends only on the RTL under rtl/; the package is not needed by the ports.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 32;
  localparam int TOTAL_ITEMS = 480;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {
    VAL_RANDOM,
    VAL_DUPS,
    VAL_RISING,
    VAL_FALLING,
    VAL_EXTREME
  } value_style_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        dropped;
  } sorted_elem_t;

  class sort_scoreboard;
    int depth;
    logic signed [31:0] held[$];
    bit dropped;
    sorted_elem_t sorted_due[$];
    int errors;
    int shown;

    function new(int store_depth);
      depth = store_depth;
      dropped = 0;
      errors = 0;
      shown = 0;
    endfunction

    function void load_element(logic [31:0] value, logic last);
      int i;
      int j;
      logic signed [31:0] key;
      sorted_elem_t e;
      if (held.size() < depth) begin
        held.push_back(value);
      end else begin
        dropped = 1;
      end
      if (!last) return;
      for (i = 1; i < held.size(); i++) begin
        key = held[i];
        j = i - 1;
        while (j >= 0 && held[j] > key) begin
          held[j + 1] = held[j];
          j--;
        end
        held[j + 1] = key;
      end
      for (i = 0; i < held.size(); i++) begin
        e.value = held[i];
        e.last = (i == held.size() - 1);
        e.dropped = dropped;
        sorted_due.push_back(e);
      end
      held.delete();
      dropped = 0;
    endfunction

    function void check_sorted(logic [31:0] value, logic last, logic ovf);
      sorted_elem_t e;
      if (sorted_due.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("sorted output error: unexpected item value=%0d last=%0b overflow=%0b",
                   $signed(value), last, ovf);
        end
        return;
      end
      e = sorted_due.pop_front();
      if (e.value !== value || e.last !== last || e.dropped !== ovf) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("sorted output error: expected value=%0d last=%0b overflow=%0b,",
                   $signed(e.value), e.last, e.dropped,
                   " got value=%0d last=%0b overflow=%0b",
                   $signed(value), last, ovf);
        end
      end
    endfunction

    function int pending();
      return sorted_due.size();
    endfunction

    function void close_out();
      if (sorted_due.size() != 0) begin
        errors += sorted_due.size();
        $display("sorted output error: %0d items never arrived", sorted_due.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;  // value
  logic        in_tlast = 1'b0;  // is_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // value_res
  logic        out_tlast;  // is_last_res
  logic [0:0]  out_tuser;  // overflow

  sort_scoreboard sort_sb;
  int items_sent = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;
  bit hold_output = 0;
  logic [31:0] directed_vals[$];
  int directed_lens[$];

  quicksort_engine #(.DEPTH(STORE_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_element(input logic [31:0] value, input logic last);
    int gap;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_set(input int count, input value_style_t style);
    logic [31:0] base;
    logic [31:0] step;
    logic [31:0] value;
    int i;
    base = $urandom;
    step = $urandom_range(1, 1000);
    for (i = 0; i < count; i++) begin
      case (style)
        VAL_DUPS: value = 32'($urandom_range(0, 6)) - 32'd3;
        VAL_RISING: value = base + step * i;
        VAL_FALLING: value = base - step * i;
        VAL_EXTREME: begin
          case ($urandom_range(0, 4))
            0: value = 32'h8000_0000;
            1: value = 32'h7fff_ffff;
            2: value = 32'h0000_0000;
            3: value = 32'hffff_ffff;
            default: value = 32'h0000_0001;
          endcase
        end
        default: value = $urandom;
      endcase
      send_element(value, i == count - 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sort_sb.load_element(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sort_sb.check_sorted(out_tdata, out_tlast, out_tuser[0]);
    end
  end

  // The receiver's stalls run on their own, including one long hold-off.
  initial begin
    int stall;
    int run;
    forever begin
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 0;
      end else begin
        stall = pick_gap(quiet_out);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        run = $urandom_range(1, 8);
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("quicksort_engine: mismatch");
    $finish;
  end

  initial begin
    int set_idx;
    int count;
    int pos;
    int i;
    int k;
    value_style_t style;
    sort_sb = new(STORE_DEPTH);
    // Single minimum, extremes, all equal, falling and rising runs.
    directed_vals = '{32'h8000_0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
                      32'd5, 32'd5, 32'd5, 32'd5,
                      32'd3, 32'd2, 32'd1, 32'd0, 32'hffff_ffff, 32'hffff_fffe,
                      32'h8000_0000, 32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff};
    directed_lens = '{1, 5, 4, 6, 4};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pos = 0;
    for (i = 0; i < directed_lens.size(); i++) begin
      for (k = 0; k < directed_lens[i]; k++) begin
        send_element(directed_vals[pos], k == directed_lens[i] - 1);
        pos++;
      end
    end

    set_idx = 0;
    while (items_sent < TOTAL_ITEMS) begin
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: count = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
        1: count = $urandom_range(STORE_DEPTH - 1, STORE_DEPTH);
        default: count = $urandom_range(1, 16);
      endcase
      if (set_idx == 3) begin
        hold_output = 1;
        count = STORE_DEPTH;
      end
      style = value_style_t'($urandom_range(0, 4));
      send_set(count, style);
      set_idx++;
    end
    in_tvalid <= 1'b0;

    // Let the monitor note the final item before the expected results are counted.
    @(posedge clk);
    while (sort_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sort_sb.close_out();
    if (sort_sb.errors == 0) begin
      $display("quicksort_engine: match");
    end else begin
      $display("quicksort_engine: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/qse_pkg.sv
rtl/quicksort_engine.sv
sim/testbench.sv
